// File: rtl/hsvrgb_pkg.sv
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Widths, constants and helpers shared by the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

	localparam int HUE_BITS     = 16;
	localparam int CHANNEL_BITS = 8;

	localparam int SECT_BITS = 3;
	localparam int SIX_BITS  = HUE_BITS + SECT_BITS;
	localparam int PROD_BITS = HUE_BITS + CHANNEL_BITS;
	localparam int WIDE_BITS = HUE_BITS + 2 * CHANNEL_BITS;
	localparam int SQ_BITS   = 2 * CHANNEL_BITS;
	localparam int EST_BITS  = 3 * CHANNEL_BITS + 1;

	localparam int IN_DATA_BITS  = ((HUE_BITS + 2 * CHANNEL_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = ((3 * CHANNEL_BITS + 7) / 8) * 8;

	// full-scale channel value M = 2^CHANNEL_BITS - 1
	localparam logic [CHANNEL_BITS-1:0] CH_MAX = {CHANNEL_BITS{1'b1}};
	// one full turn of hue
	localparam logic [HUE_BITS:0] HUE_TURN = {1'b1, {HUE_BITS{1'b0}}};
	// D*M and D*M/2
	localparam logic [PROD_BITS-1:0] DM = {CH_MAX, {HUE_BITS{1'b0}}};
	localparam logic [WIDE_BITS-1:0] HALF_DM =
		WIDE_BITS'({CH_MAX, {(HUE_BITS - 1){1'b0}}});
	localparam logic [SQ_BITS-1:0] HALF_M = SQ_BITS'(CH_MAX >> 1);
	// M + 2 = 2^CHANNEL_BITS + 1, reciprocal of M scaled by 2^(2*CHANNEL_BITS)
	localparam logic [CHANNEL_BITS:0] RECIP = {1'b1, {(CHANNEL_BITS - 1){1'b0}}, 1'b1};

	typedef enum logic [SECT_BITS-1:0] {
		SECT_RED_YEL = 3'd0,
		SECT_YEL_GRN = 3'd1,
		SECT_GRN_CYN = 3'd2,
		SECT_CYN_BLU = 3'd3,
		SECT_BLU_MAG = 3'd4,
		SECT_MAG_RED = 3'd5
	} sector_t;

	// x / M given an estimate that is exact or one short
	function automatic logic [CHANNEL_BITS-1:0] div_fix(
		input logic [SQ_BITS-1:0]    x,
		input logic [CHANNEL_BITS:0] est
	);
		logic [SQ_BITS:0]        rem;
		logic [CHANNEL_BITS:0]   quo;
		rem = {1'b0, x} - ((SQ_BITS + 1)'(est) << CHANNEL_BITS) + (SQ_BITS + 1)'(est);
		quo = est;
		if (rem >= (SQ_BITS + 1)'(CH_MAX)) begin
			quo = est + 1'b1;
		end
		return quo[CHANNEL_BITS-1:0];
	endfunction

endpackage

// File: rtl/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Pipelined HSV to RGB colour conversion, one colour per clock while m_tready stays high.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_* carries one HSV colour per beat; master stream m_*
//   returns the matching RGB colour, in order, one beat per input beat.
//   Hue is a fraction of a turn, saturation and value are x/255; each
//   output channel is the exact result times 255, rounded half up.
//   Each accepted beat passes five register stages: sector split, products
//   with saturation, products with value, reciprocal estimate of the /255,
//   correction and channel select.
//   Throughput is one beat per cycle while m_tready stays high.
//   Each stage holds its beat while the next one is full; a stall on m_tready
//   backs up stage by stage, empty stages still fill, and s_tready drops only
//   once all five stages hold a beat.
//   The final stage is the output register.
//   Reset (arst_n low) empties the pipeline; no beats are in flight after it.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter import hsvrgb_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [IN_DATA_BITS-1:0]  s_tdata,  // hue, saturation, brightness
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_DATA_BITS-1:0] m_tdata   // red, green, blue
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5 = !vld_s5 || m_tready;
	assign rdy4 = !vld_s4 || rdy5;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;
	assign s_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= s_tvalid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
		end
	end

	// stage 1: hue*6 into sector and fraction
	logic [HUE_BITS-1:0]     hue_in;
	logic [CHANNEL_BITS-1:0] sat_in, bri_in;
	logic [SIX_BITS-1:0]     six;

	assign hue_in = s_tdata[0 +: HUE_BITS];
	assign sat_in = s_tdata[HUE_BITS +: CHANNEL_BITS];
	assign bri_in = s_tdata[HUE_BITS + CHANNEL_BITS +: CHANNEL_BITS];
	assign six    = (SIX_BITS'(hue_in) << 2) + (SIX_BITS'(hue_in) << 1);

	sector_t                 sect_s1;
	logic [HUE_BITS-1:0]     frac_s1;
	logic [CHANNEL_BITS-1:0] sat_s1, bri_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			sect_s1 <= sector_t'(six[SIX_BITS-1 -: SECT_BITS]);
			frac_s1 <= six[HUE_BITS-1:0];
			sat_s1  <= sat_in;
			bri_s1  <= bri_in;
		end
	end

	// stage 2: f*s, (1-f)*s and v*(1-s)
	logic [HUE_BITS:0]                cofrac;
	logic [HUE_BITS+CHANNEL_BITS:0]   gs_full;

	assign cofrac  = HUE_TURN - {1'b0, frac_s1};
	assign gs_full = cofrac * sat_s1;

	sector_t                 sect_s2;
	logic [CHANNEL_BITS-1:0] bri_s2;
	logic [PROD_BITS-1:0]    fs_s2, gs_s2;
	logic [SQ_BITS-1:0]      pp_s2;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			sect_s2 <= sect_s1;
			bri_s2  <= bri_s1;
			fs_s2   <= frac_s1 * sat_s1;
			gs_s2   <= gs_full[PROD_BITS-1:0];
			pp_s2   <= bri_s1 * (CH_MAX - sat_s1);
		end
	end

	// stage 3: scale by value; rounding offset for p
	logic [PROD_BITS-1:0] qn, tn;

	assign qn = DM - fs_s2;
	assign tn = DM - gs_s2;

	sector_t                 sect_s3;
	logic [CHANNEL_BITS-1:0] bri_s3;
	logic [WIDE_BITS-1:0]    qv_s3, tv_s3;
	logic [SQ_BITS-1:0]      xp_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			sect_s3 <= sect_s2;
			bri_s3  <= bri_s2;
			qv_s3   <= bri_s2 * qn;
			tv_s3   <= bri_s2 * tn;
			xp_s3   <= pp_s2 + HALF_M;
		end
	end

	// stage 4: drop the hue scale with rounding, estimate x/M
	logic [WIDE_BITS-1:0] qr, tr;
	logic [SQ_BITS-1:0]   xq, xt;
	logic [EST_BITS-1:0]  eq_full, et_full, ep_full;

	assign qr      = qv_s3 + HALF_DM;
	assign tr      = tv_s3 + HALF_DM;
	assign xq      = qr[WIDE_BITS-1:HUE_BITS];
	assign xt      = tr[WIDE_BITS-1:HUE_BITS];
	assign eq_full = xq * RECIP;
	assign et_full = xt * RECIP;
	assign ep_full = xp_s3 * RECIP;

	sector_t                 sect_s4;
	logic [CHANNEL_BITS-1:0] bri_s4;
	logic [SQ_BITS-1:0]      xq_s4, xt_s4, xp_s4;
	logic [CHANNEL_BITS:0]   eq_s4, et_s4, ep_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			sect_s4 <= sect_s3;
			bri_s4  <= bri_s3;
			xq_s4   <= xq;
			xt_s4   <= xt;
			xp_s4   <= xp_s3;
			eq_s4   <= eq_full[EST_BITS-1:SQ_BITS];
			et_s4   <= et_full[EST_BITS-1:SQ_BITS];
			ep_s4   <= ep_full[EST_BITS-1:SQ_BITS];
		end
	end

	// stage 5: correct estimates, pick the triple by sector
	logic [CHANNEL_BITS-1:0] pc, qc, tc;
	logic [CHANNEL_BITS-1:0] rc, gc, bc;

	assign pc = div_fix(xp_s4, ep_s4);
	assign qc = div_fix(xq_s4, eq_s4);
	assign tc = div_fix(xt_s4, et_s4);

	always_comb begin
		unique case (sect_s4)
			SECT_RED_YEL: begin rc = bri_s4; gc = tc;     bc = pc;     end
			SECT_YEL_GRN: begin rc = qc;     gc = bri_s4; bc = pc;     end
			SECT_GRN_CYN: begin rc = pc;     gc = bri_s4; bc = tc;     end
			SECT_CYN_BLU: begin rc = pc;     gc = qc;     bc = bri_s4; end
			SECT_BLU_MAG: begin rc = tc;     gc = pc;     bc = bri_s4; end
			default:      begin rc = bri_s4; gc = pc;     bc = qc;     end
		endcase
	end

	logic [CHANNEL_BITS-1:0] red_s5, green_s5, blue_s5;

	always_ff @(posedge clk) begin
		if (rdy5) begin
			red_s5   <= rc;
			green_s5 <= gc;
			blue_s5  <= bc;
		end
	end

	assign m_tvalid = vld_s5;
	assign m_tdata  = OUT_DATA_BITS'({blue_s5, green_s5, red_s5});

endmodule

// File: rtl/hsvrgb_checker.sv
// ----------------------------------------------------------------------------
// hsvrgb_checker
// Port-level checks on the HSV to RGB converter, bound to the top level.
// ----------------------------------------------------------------------------
module hsvrgb_checker import hsvrgb_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     s_tvalid,
	input logic                     s_tready,
	input logic [IN_DATA_BITS-1:0]  s_tdata,  // hue, saturation, brightness
	input logic                     m_tvalid,
	input logic                     m_tready,
	input logic [OUT_DATA_BITS-1:0] m_tdata   // red, green, blue
);

	// stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	// input back-pressure only when the output side is stalled
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("s_tready low without output stall");

	// an accepted beat reaches the output while m_tready stays high
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready
		|=> m_tvalid)
		else $error("beat missing after pipeline latency");

	// zero saturation gives grey at the input brightness
	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tdata[HUE_BITS +: CHANNEL_BITS] == '0)
		##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready
		|=> (m_tdata[0 +: CHANNEL_BITS] ==
			$past(s_tdata[HUE_BITS + CHANNEL_BITS +: CHANNEL_BITS], 5))
		&& (m_tdata[CHANNEL_BITS +: CHANNEL_BITS] == m_tdata[0 +: CHANNEL_BITS])
		&& (m_tdata[2 * CHANNEL_BITS +: CHANNEL_BITS] == m_tdata[0 +: CHANNEL_BITS]))
		else $error("unsaturated colour is not grey");

endmodule

bind hsv_to_rgb_converter hsvrgb_checker u_hsvrgb_checker (.*);

// File: tb/sv/hsv_to_rgb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_checker
// Watches both streams of the HSV to RGB converter, works out the RGB colour
// due for every accepted HSV beat and compares each output beat against it.
// ----------------------------------------------------------------------------
module hsv_to_rgb_checker import hsvrgb_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	input  logic                     s_tready,
	input  logic [IN_DATA_BITS-1:0]  s_tdata,  // hue, saturation, brightness
	input  logic                     m_tvalid,
	input  logic                     m_tready,
	input  logic [OUT_DATA_BITS-1:0] m_tdata,  // red, green, blue
	output int                       errors,
	output int                       pending
);

	typedef struct {
		logic [CHANNEL_BITS-1:0] red;
		logic [CHANNEL_BITS-1:0] green;
		logic [CHANNEL_BITS-1:0] blue;
	} rgb_t;

	rgb_t rgb_due[$];
	int   fail_cnt = 0;

	assign errors  = fail_cnt;

	// num/den rounded, halfway goes up
	function automatic longint unsigned round_half_up(
		input longint unsigned num,
		input longint unsigned den
	);
		return (2 * num + den) / (2 * den);
	endfunction

	function automatic rgb_t rgb_of_hsv(
		input logic [HUE_BITS-1:0]     hue,
		input logic [CHANNEL_BITS-1:0] sat,
		input logic [CHANNEL_BITS-1:0] val
	);
		longint unsigned turn, full, turn_full, six, frac, sv, vv, pc, qc, tc;
		sector_t         sect;
		rgb_t            c;
		turn      = 64'd1 << HUE_BITS;
		full      = (64'd1 << CHANNEL_BITS) - 1;
		turn_full = turn * full;
		sv        = 64'(sat);
		vv        = 64'(val);
		six       = 64'd6 * 64'(hue);
		sect      = sector_t'(SECT_BITS'(six >> HUE_BITS));
		frac      = six & (turn - 1);
		pc = round_half_up(vv * (full - sv), full);
		qc = round_half_up(vv * (turn_full - frac * sv), turn_full);
		tc = round_half_up(vv * (turn_full - (turn - frac) * sv), turn_full);
		case (sect)
			SECT_RED_YEL: begin
				c.red = val;              c.green = CHANNEL_BITS'(tc); c.blue = CHANNEL_BITS'(pc);
			end
			SECT_YEL_GRN: begin
				c.red = CHANNEL_BITS'(qc); c.green = val;              c.blue = CHANNEL_BITS'(pc);
			end
			SECT_GRN_CYN: begin
				c.red = CHANNEL_BITS'(pc); c.green = val;              c.blue = CHANNEL_BITS'(tc);
			end
			SECT_CYN_BLU: begin
				c.red = CHANNEL_BITS'(pc); c.green = CHANNEL_BITS'(qc); c.blue = val;
			end
			SECT_BLU_MAG: begin
				c.red = CHANNEL_BITS'(tc); c.green = CHANNEL_BITS'(pc); c.blue = val;
			end
			default: begin
				c.red = val;              c.green = CHANNEL_BITS'(pc); c.blue = CHANNEL_BITS'(qc);
			end
		endcase
		return c;
	endfunction

	task automatic check_channel(
		input string                   chan,
		input logic [CHANNEL_BITS-1:0] want,
		input logic [CHANNEL_BITS-1:0] got
	);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, chan, want, got);
			fail_cnt++;
		end
	endtask

	always @(posedge clk) begin
		rgb_t want;
		if (arst_n && s_tvalid && s_tready) begin
			rgb_due = {rgb_due, rgb_of_hsv(s_tdata[HUE_BITS-1:0],
				s_tdata[HUE_BITS +: CHANNEL_BITS],
				s_tdata[HUE_BITS + CHANNEL_BITS +: CHANNEL_BITS])};
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (rgb_due.size() == 0) begin
				$display("%0t ns: unexpected output beat, expected none, actual %h",
					$time, m_tdata);
				fail_cnt++;
			end else begin
				want = rgb_due.pop_front();
				check_channel("red",   want.red,   m_tdata[0 +: CHANNEL_BITS]);
				check_channel("green", want.green, m_tdata[CHANNEL_BITS +: CHANNEL_BITS]);
				check_channel("blue",  want.blue,  m_tdata[2 * CHANNEL_BITS +: CHANNEL_BITS]);
			end
		end
		pending = rgb_due.size();
	end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the HSV to RGB converter: directed corner colours,
// then random colours under several idle and stall mixes, with a long output
// hold-off and a full drain along the way.
// ----------------------------------------------------------------------------
module tb;
	import hsvrgb_pkg::*;

	logic                     clk      = 1'b0;
	logic                     arst_n   = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [IN_DATA_BITS-1:0]  s_tdata  = '0;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_tdata;

	int errors;
	int pending;

	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int hold_trig      = 0;
	int hold_ack       = 0;
	int hold_cnt       = 0;

	always #2 clk = ~clk;

	hsv_to_rgb_converter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	hsv_to_rgb_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending)
	);

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_trig != hold_ack) begin
			hold_ack <= hold_trig;
			hold_cnt <= 120;
			m_tready <= 1'b0;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	initial begin
		#2ms;
		$display("end of test: mismatches");
		$finish;
	end

	task automatic send_colour(
		input logic [HUE_BITS-1:0]     hue,
		input logic [CHANNEL_BITS-1:0] sat,
		input logic [CHANNEL_BITS-1:0] val
	);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_DATA_BITS'({val, sat, hue});
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// random colours, biased towards sector edges and extreme channels
	task automatic send_random(input int count);
		logic [HUE_BITS-1:0]     hue;
		logic [CHANNEL_BITS-1:0] sat, val;
		int                      edge_idx;
		for (int i = 0; i < count; i++) begin
			hue = HUE_BITS'($urandom);
			sat = CHANNEL_BITS'($urandom);
			val = CHANNEL_BITS'($urandom);
			if ($urandom_range(9) < 2) begin
				edge_idx = $urandom_range(6);
				hue = HUE_BITS'((edge_idx * 65536) / 6 + $urandom_range(2) - 1);
			end
			if ($urandom_range(9) == 0) sat = $urandom_range(1) ? CH_MAX : '0;
			if ($urandom_range(9) == 0) val = $urandom_range(1) ? CH_MAX : '0;
			send_colour(hue, sat, val);
		end
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners: black, white, pure hues at sector edges, and halfway ties
		send_colour(16'd0,     8'd0,   8'd0);
		send_colour(16'd0,     8'd255, 8'd255);
		send_colour(16'd65535, 8'd255, 8'd255);
		send_colour(16'd65535, 8'd0,   8'd255);
		send_colour(16'd65535, 8'd255, 8'd0);
		send_colour(16'd10922, 8'd255, 8'd255);
		send_colour(16'd10923, 8'd255, 8'd255);
		send_colour(16'd21845, 8'd255, 8'd255);
		send_colour(16'd21846, 8'd255, 8'd255);
		send_colour(16'd32768, 8'd200, 8'd255);
		send_colour(16'd43690, 8'd255, 8'd255);
		send_colour(16'd43691, 8'd255, 8'd255);
		send_colour(16'd54613, 8'd255, 8'd255);
		send_colour(16'd54614, 8'd128, 8'd255);
		send_colour(16'd16384, 8'd255, 8'd1);
		send_colour(16'd16384, 8'd255, 8'd3);
		send_colour(16'd49152, 8'd255, 8'd1);
		send_colour(16'h1234,  8'hA5,  8'h5A);
		send_colour(16'hEDCB,  8'h5A,  8'hA5);
		drain();

		// full rate, then a long output hold-off while the input keeps coming
		src_idle_pct   = 0;
		sink_stall_pct <= 0;
		send_random(300);
		hold_trig <= hold_trig + 1;
		send_random(120);
		drain();

		src_idle_pct   = 76;
		sink_stall_pct <= 0;
		send_random(420);
		drain();

		src_idle_pct   = 0;
		sink_stall_pct <= 76;
		send_random(420);

		src_idle_pct   = 17;
		sink_stall_pct <= 17;
		send_random(420);
		drain();

		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/hsvrgb_pkg.sv
rtl/hsv_to_rgb_converter.sv
rtl/hsvrgb_checker.sv
tb/sv/hsv_to_rgb_checker.sv
tb/sv/tb.sv
